@@ rtl/core/utli_pkg.sv @@
package utli_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_INTERP = 2'd1,
    CMD_POINT  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_GRID_START   = 2'd0,
    REG_GRID_STEP    = 2'd1,
    REG_SAMPLE_COUNT = 2'd2
  } cfg_reg_e;

  localparam int unsigned KW = 16;

  typedef struct packed {
    cmd_e               command;
    logic [9:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] query_x;
  } req_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               status;
  } rsp_t;

  // one in-flight request, carried stage to stage
  typedef struct packed {
    cmd_e          cmd;
    logic [9:0]    idx;
    logic [31:0]   wdata;
    logic [31:0]   x;
    logic          oor;
    logic          wr_ok;
    logic          last;
    logic          neg;
    logic [KW-1:0] k;
    logic [62:0]   rem;
    logic [40:0]   pprod;
    logic [31:0]   px;
    logic [KW-1:0] addr_a;
    logic [KW-1:0] addr_b;
    logic [31:0]   y0;
    logic [32:0]   diff;
    logic [46:0]   plo;
    logic [47:0]   phi;
    logic [31:0]   qu;
  } item_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/uniform_table_linear_interp.sv @@
// Uniform-grid lookup table with linear interpolation, Q16.16.
// Request channel (in_valid_i/in_ready_o, in_req_i): a write request stores one
// sample and gives no response; an interpolate request returns the value at
// query_x; a point request returns the abscissa and value of one sample.
// Response channel (out_valid_o/out_ready_i, out_rsp_o): one response per
// interpolate or point request, in request order.
// Configuration channel (cfg_valid_i/cfg_ready_o): always ready; write only
// while no request is in flight.
// The pipeline has 40 + ceil(log2(TABLE_DEPTH)) stages (50 at the default
// depth): input, subtract and range check, one per quotient bit of the segment
// divider, address, table read, difference, two multiply, one per bit of the
// 32-bit fraction divider, and result. One request per cycle is accepted while
// the pipeline is not held.
// The response register is the last stage; while it holds an unaccepted
// response the whole pipeline holds and in_ready_o is low.
// Reset clears the stage valid bits and sets grid_start 0, grid_step 1.0,
// sample_count 1. Table contents are undefined until written.
module uniform_table_linear_interp #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  utli_pkg::req_t      in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output utli_pkg::rsp_t      out_rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  localparam int unsigned AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned S_ADDR = 2 + AW;
  localparam int unsigned S_MEM  = 3 + AW;
  localparam int unsigned S_DIFF = 4 + AW;
  localparam int unsigned S_P1   = 5 + AW;
  localparam int unsigned S_P2   = 6 + AW;
  localparam int unsigned S_QD   = 7 + AW;
  localparam int unsigned NS     = 40 + AW;

  logic [31:0] start_q;
  logic [30:0] step_raw_q;
  logic [10:0] count_raw_q;
  logic [30:0] s_q;
  logic [16:0] n_q;
  logic signed [48:0] end_q;

  utli_pkg::item_t pipe_q [NS];
  utli_pkg::item_t nxt    [NS];
  logic [NS-1:0]   vld_q;
  logic            en;

  logic [31:0] rd_a;
  logic [31:0] rd_b;
  logic        mem_we;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      step_raw_q  <= 31'd65536;
      count_raw_q <= 11'd1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == utli_pkg::REG_GRID_START) begin
        start_q <= cfg_data_i;
      end else if (cfg_index_i == utli_pkg::REG_GRID_STEP) begin
        step_raw_q <= cfg_data_i[30:0];
      end else if (cfg_index_i == utli_pkg::REG_SAMPLE_COUNT) begin
        count_raw_q <= cfg_data_i[10:0];
      end
    end
  end

  // effective step/count, then grid end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q   <= 31'd65536;
      n_q   <= 17'd1;
      end_q <= '0;
    end else begin
      s_q <= (step_raw_q == '0) ? 31'd1 : step_raw_q;
      if (count_raw_q == '0) begin
        n_q <= 17'd1;
      end else if ({6'b0, count_raw_q} > 17'(TABLE_DEPTH)) begin
        n_q <= 17'(TABLE_DEPTH);
      end else begin
        n_q <= {6'b0, count_raw_q};
      end
      end_q <= $signed({{17{start_q[31]}}, start_q})
             + $signed({1'b0, 48'((n_q - 17'd1) * s_q)});
    end
  end

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;

  always_comb begin
    utli_pkg::item_t t;
    logic [32:0]        d;
    logic [63:0]        sh;
    logic signed [42:0] pxs;
    logic signed [48:0] phw;
    logic signed [63:0] num;
    logic [32:0]        q33;
    logic [33:0]        res;
    for (int i = 0; i < NS; i++) begin
      nxt[i] = pipe_q[i];
    end

    t       = '0;
    t.cmd   = in_req_i.command;
    t.idx   = in_req_i.entry_index;
    t.wdata = in_req_i.entry_value;
    t.x     = in_req_i.query_x;
    nxt[0]  = t;

    t       = pipe_q[0];
    d       = {t.x[31], t.x} - {start_q[31], start_q};
    t.rem   = {30'b0, d};
    t.k     = '0;
    t.pprod = t.idx * s_q;
    t.wr_ok = {7'b0, t.idx} < 17'(TABLE_DEPTH);
    if (t.cmd == utli_pkg::CMD_POINT) begin
      t.oor = {7'b0, t.idx} >= n_q;
    end else begin
      t.oor = $signed(t.x) < $signed(start_q);
    end
    nxt[1] = t;

    for (int j = 0; j < AW; j++) begin
      t = pipe_q[1+j];
      if (j == 0) begin
        if (t.cmd == utli_pkg::CMD_INTERP &&
            $signed({{17{t.x[31]}}, t.x}) > end_q) begin
          t.oor = 1'b1;
        end
        pxs  = $signed({{11{start_q[31]}}, start_q}) + $signed({2'b0, t.pprod});
        t.px = utli_pkg::sat32(64'(pxs));
      end
      sh = {33'b0, s_q} << (AW - 1 - j);
      if ({1'b0, t.rem} >= sh) begin
        t.rem            = t.rem - sh[62:0];
        t.k[AW - 1 - j]  = 1'b1;
      end
      nxt[2+j] = t;
    end

    t        = pipe_q[S_ADDR-1];
    t.last   = {1'b0, t.k} >= (n_q - 17'd1);
    t.addr_b = t.k + 1'b1;
    if (t.cmd == utli_pkg::CMD_POINT || t.cmd == utli_pkg::CMD_WRITE) begin
      t.addr_a = {6'b0, t.idx};
    end else if (t.last) begin
      t.addr_a = 16'(n_q - 17'd1);
    end else begin
      t.addr_a = t.k;
    end
    nxt[S_ADDR] = t;

    nxt[S_MEM] = pipe_q[S_ADDR];

    t         = pipe_q[S_MEM];
    t.y0      = rd_a;
    t.diff    = {rd_b[31], rd_b} - {rd_a[31], rd_a};
    nxt[S_DIFF] = t;

    t     = pipe_q[S_DIFF];
    t.plo = t.rem[30:0] * t.diff[15:0];
    phw   = $signed({1'b0, t.rem[30:0]}) * $signed(t.diff[32:16]);
    t.phi = phw[47:0];
    nxt[S_P1] = t;

    t     = pipe_q[S_P1];
    num   = $signed({t.phi, 16'b0}) + $signed({17'b0, t.plo});
    t.neg = num[63];
    t.rem = t.neg ? ~num[62:0] : num[62:0];
    t.qu  = '0;
    nxt[S_P2] = t;

    for (int j = 0; j < 32; j++) begin
      t  = pipe_q[S_P2+j];
      sh = {33'b0, s_q} << (31 - j);
      if ({1'b0, t.rem} >= sh) begin
        t.rem        = t.rem - sh[62:0];
        t.qu[31 - j] = 1'b1;
      end
      nxt[S_QD+j] = t;
    end

    t   = pipe_q[NS-2];
    q33 = t.neg ? ~{1'b0, t.qu} : {1'b0, t.qu};
    res = {{2{t.y0[31]}}, t.y0} + {q33[32], q33};
    if (t.cmd == utli_pkg::CMD_POINT) begin
      t.px = t.oor ? 32'd0 : t.px;
      t.y0 = t.oor ? 32'd0 : t.y0;
    end else begin
      t.px = t.x;
      if (t.oor) begin
        t.y0 = 32'd0;
      end else if (!t.last) begin
        t.y0 = utli_pkg::sat32(64'($signed(res)));
      end
    end
    nxt[NS-1] = t;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NS; i++) begin
        pipe_q[i] <= nxt[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  assign mem_we = vld_q[S_ADDR] && pipe_q[S_ADDR].cmd == utli_pkg::CMD_WRITE
                  && pipe_q[S_ADDR].wr_ok;

  utli_table #(
    .Depth (TABLE_DEPTH),
    .Aw    (AW)
  ) u_table (
    .clk_i     (clk_i),
    .en_i      (en),
    .we_i      (mem_we),
    .waddr_i   (pipe_q[S_ADDR].addr_a[AW-1:0]),
    .wdata_i   (pipe_q[S_ADDR].wdata),
    .raddr_a_i (pipe_q[S_ADDR].addr_a[AW-1:0]),
    .raddr_b_i (pipe_q[S_ADDR].addr_b[AW-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign out_valid_o = vld_q[NS-1] &&
                       (pipe_q[NS-1].cmd == utli_pkg::CMD_INTERP ||
                        pipe_q[NS-1].cmd == utli_pkg::CMD_POINT);
  assign out_rsp_o.point_x = pipe_q[NS-1].px;
  assign out_rsp_o.point_y = pipe_q[NS-1].y0;
  assign out_rsp_o.status  = pipe_q[NS-1].oor;

  a_oor_zero_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status |-> out_rsp_o.point_y == 32'd0)
    else $error("out-of-range response with nonzero value");

  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_q != '0)
    else $error("effective step is zero");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q != '0 && n_q <= 17'(TABLE_DEPTH))
    else $error("effective count out of range");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(vld_q))
    else $error("pipeline moved while response stalled");

endmodule

@@ rtl/core/utli_table.sv @@
module utli_table #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Aw    = 10
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [Aw-1:0] raddr_a_i,
  input  logic [Aw-1:0] raddr_b_i,
  output logic [31:0]   rdata_a_o,
  output logic [31:0]   rdata_b_o
);

  logic [31:0] mem_q [Depth];
  logic [31:0] rdata_a_q;
  logic [31:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
